// ===== src/tplm_pkg.sv =====
// ----------------------------------------------------------------------------
// tplm_pkg
// Shared types, codes and helpers for the track position LED matrix block.
// ----------------------------------------------------------------------------
package tplm_pkg;

	localparam int MATRIX_ROWS   = 8;
	localparam int MATRIX_HALVES = 2;
	localparam int ROW_W         = $clog2(MATRIX_ROWS);

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_DATA_W = 3;

	localparam logic [0:0] OP_TRACK = 1'b0;
	localparam logic [0:0] OP_SCAN  = 1'b1;

	localparam logic [0:0] REG_DISPLAY_MODE = 1'b0;
	localparam logic [0:0] REG_DRIVE_ENABLE = 1'b1;

	localparam logic [2:0] MODE_POS       = 3'd0;
	localparam logic [2:0] MODE_POS_ROT   = 3'd1;
	localparam logic [2:0] MODE_METER     = 3'd2;
	localparam logic [2:0] MODE_METER_ROT = 3'd3;
	localparam logic [2:0] MODE_DOT       = 3'd4;
	localparam logic [2:0] MODE_DOT_ROT   = 3'd5;

	localparam logic [1:0] DRIVE_OFF      = 2'd0;
	localparam logic [1:0] DRIVE_NORMAL   = 2'd1;
	localparam logic [1:0] DRIVE_INVERTED = 2'd2;

	localparam logic LAYER_GREEN = 1'b0;
	localparam logic LAYER_RED   = 1'b1;

	// [half][layer][row] -> byte, bit c is matrix column c
	typedef logic [MATRIX_HALVES-1:0][1:0][MATRIX_ROWS-1:0][7:0] store_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic mark;
		logic scan;
	} ctrl_cmd_t;

	typedef struct packed {
		logic disp_on;
	} dp_stat_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int b = 0; b < 8; b++) begin
			r[7-b] = v[b];
		end
		return r;
	endfunction

endpackage

// ===== src/track_position_led_matrix_core.sv =====
// ----------------------------------------------------------------------------
// track_position_led_matrix_core
// 16x8 two-color LED matrix renderer and row scanner for sequencer tracks.
// ----------------------------------------------------------------------------
// Track item: accept, three quotient steps, then the mark write.
// Scan tick: result valid the cycle after transfer; one tick per cycle when
//   no track item is in progress and the result is taken at once.
// Throughput is set by the three-step restoring quotient and the store write.
// Reset clears frame store and row counter at once; mode 0, drive normal.
// ----------------------------------------------------------------------------
module track_position_led_matrix_core
	import tplm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// track_index, last_step, current_step, track_muted, track_selected,
	// meter_level, frame_start, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// scan_row, column_select, green_left, green_right, red_left, red_right,
	// zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	tplm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.opcode    (s_tuser),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd),
		.stat      (stat)
	);

	tplm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_data  (m_tdata)
	);

endmodule

// ===== src/tplm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tplm_ctrl
// Controller: sequences track items through the quotient steps and the
// frame store update, issues scan loads and owns the output valid flag.
// ----------------------------------------------------------------------------
module tplm_ctrl
	import tplm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      opcode,
	input  logic      out_ready,
	output logic      in_ready,
	output logic      out_valid,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MARK
	} state_t;

	state_t     state_q;
	logic [1:0] cnt_q;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd.load     = accept && stat.disp_on && (opcode == OP_TRACK);
		cmd.scan     = accept && stat.disp_on && (opcode == OP_SCAN);
		cmd.div_step = (state_q == ST_DIV);
		cmd.mark     = (state_q == ST_MARK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.load) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_mark_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MARK |=> state_q == ST_IDLE)
		else $error("mark step not followed by idle");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == 2'd2) |=> state_q == ST_MARK)
		else $error("quotient did not finish in three steps");

	a_scan_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |=> out_valid_q)
		else $error("scan load lost its result");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !(cmd.load || cmd.scan))
		else $error("item taken while busy");

endmodule

// ===== src/tplm_dp.sv =====
// ----------------------------------------------------------------------------
// tplm_dp
// Datapath: configuration registers, frame store, position quotient, mark
// writer, row counter and output register.
// ----------------------------------------------------------------------------
module tplm_dp
	import tplm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_stat_t              stat,
	input  logic                  cfg_valid,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_DATA_W-1:0]  in_data,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic [2:0]       mode_q;
	logic [1:0]       drive_q;
	store_t           store_q;
	store_t           store_d;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] row_nxt;

	logic             half_q;
	logic [2:0]       trow_q;
	logic             muted_q;
	logic             sel_q;
	logic [7:0]       meter_q;
	logic [8:0]       len_q;
	logic [8:0]       rem_q;
	logic [2:0]       quo_q;
	logic             sat_q;
	logic [OUT_DATA_W-1:0] out_q;

	logic [8:0] rem2;
	logic [8:0] in_len;
	logic [2:0] pos;
	logic [2:0] mp;
	logic       meter_mode;
	logic       rot;
	logic       dot;
	logic [7:0] inv;

	assign stat.disp_on = (drive_q != DRIVE_OFF);
	assign out_data     = out_q;

	assign in_len  = {1'b0, in_data[11:4]} + 9'd1;
	assign rem2    = {rem_q[7:0], 1'b0};
	assign pos     = sat_q ? 3'd7 : quo_q;
	assign mp      = meter_q[6:4];
	assign row_nxt = row_q + 3'd1;
	assign inv     = (drive_q == DRIVE_INVERTED) ? 8'hff : 8'h00;

	assign meter_mode = (mode_q == MODE_METER) || (mode_q == MODE_METER_ROT) ||
		(mode_q == MODE_DOT) || (mode_q == MODE_DOT_ROT);
	assign dot = (mode_q == MODE_DOT) || (mode_q == MODE_DOT_ROT);
	assign rot = (mode_q == MODE_POS_ROT) || (mode_q == MODE_METER_ROT) ||
		(mode_q == MODE_DOT_ROT);

	always_comb begin
		store_d = store_q;
		if (cmd.load && in_data[30]) begin
			store_d = '0;
		end
		if (cmd.mark) begin
			if (meter_mode) begin
				if (!muted_q) begin
					if (rot) begin
						store_d[half_q][LAYER_RED][trow_q] = 8'd1 << pos;
					end else begin
						store_d[half_q][LAYER_RED][3'd7 - pos][trow_q] = 1'b1;
					end
				end
				if (meter_q != 8'd0) begin
					if (dot) begin
						if (rot) begin
							store_d[half_q][LAYER_GREEN][trow_q] = 8'd1 << mp;
						end else begin
							store_d[half_q][LAYER_GREEN][3'd7 - mp][trow_q] = 1'b1;
						end
					end else if (rot) begin
						store_d[half_q][LAYER_GREEN][trow_q] = 8'hff >> (3'd7 - mp);
					end else begin
						for (int i = 0; i < MATRIX_ROWS; i++) begin
							if (3'(i) <= mp) begin
								store_d[half_q][LAYER_GREEN][3'd7 - 3'(i)][trow_q] = 1'b1;
							end
						end
					end
				end
			end else begin
				if (!muted_q) begin
					if (rot) begin
						store_d[half_q][LAYER_GREEN][trow_q] = 8'd1 << pos;
					end else begin
						store_d[half_q][LAYER_GREEN][3'd7 - pos][trow_q] = 1'b1;
					end
				end
				if (sel_q) begin
					if (rot) begin
						store_d[half_q][LAYER_RED][trow_q] = 8'd1 << pos;
					end else begin
						store_d[half_q][LAYER_RED][3'd7 - pos][trow_q] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_POS;
			drive_q <= DRIVE_NORMAL;
			store_q <= '0;
			row_q   <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_DISPLAY_MODE) begin
					mode_q <= cfg_data;
				end else begin
					drive_q <= cfg_data[1:0];
				end
			end
			store_q <= store_d;
			if (cmd.scan) begin
				row_q <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			half_q  <= in_data[3];
			trow_q  <= in_data[2:0];
			len_q   <= in_len;
			muted_q <= in_data[20];
			sel_q   <= in_data[21];
			meter_q <= in_data[29:22];
			rem_q   <= {1'b0, in_data[19:12]};
			quo_q   <= '0;
			sat_q   <= ({1'b0, in_data[19:12]} >= in_len);
		end else if (cmd.div_step) begin
			if (rem2 >= len_q) begin
				rem_q <= rem2 - len_q;
				quo_q <= {quo_q[1:0], 1'b1};
			end else begin
				rem_q <= rem2;
				quo_q <= {quo_q[1:0], 1'b0};
			end
		end
		if (cmd.scan) begin
			out_q <= {5'd0,
				rev8(store_q[1][LAYER_RED][row_nxt] ^ inv),
				rev8(store_q[0][LAYER_RED][row_nxt] ^ inv),
				rev8(store_q[1][LAYER_GREEN][row_nxt] ^ inv),
				rev8(store_q[0][LAYER_GREEN][row_nxt] ^ inv),
				rev8(~(8'd1 << row_nxt) ^ inv),
				row_nxt};
		end
	end

endmodule

// ===== verif/tb_track_position_led_matrix_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_track_position_led_matrix_core
// Self-checking bench for the LED matrix renderer and row scanner. Track
// updates and scan ticks go in on the input stream, and a local frame model
// predicts every scanned row. Each row transfer is compared field by field.
// Directed cases cover field extremes, position overflow, muted and selected
// tracks, meter modes, spare mode and drive codes and the display-off case.
// Random traffic then sweeps every display mode and drive code under varying backpressure.
// ----------------------------------------------------------------------------
module tb_track_position_led_matrix_core;
	import tplm_pkg::*;

	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam logic [1:0] DRIVE_SPARE   = 2'd3;
	localparam int         PHASE_ITEMS   = 100;
	localparam int         SETTLE_CYCLES = 12;

	typedef struct {
		logic [3:0] track;
		logic [7:0] last_step;
		logic [7:0] play_step;
		logic       muted;
		logic       selected;
		logic [7:0] meter;
		logic       clear;
	} track_item_t;

	typedef struct {
		logic [2:0] row;
		logic [7:0] col_sel;
		logic [7:0] green_l;
		logic [7:0] green_r;
		logic [7:0] red_l;
		logic [7:0] red_r;
	} scan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [7:0] led_bytes [0:31];
	logic [2:0] scan_pos;
	logic [2:0] cur_mode;
	logic [1:0] cur_drive;
	scan_row_t  expected_rows [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int track_updates = 0;
	int scan_ticks = 0;
	int rows_checked = 0;

	logic [2:0] phase_mode [0:11] = '{MODE_POS, MODE_POS_ROT, MODE_METER, MODE_METER_ROT,
		MODE_DOT, MODE_DOT_ROT, MODE_SPARE_LO, MODE_SPARE_HI, MODE_METER, MODE_DOT_ROT,
		MODE_POS, MODE_METER_ROT};
	logic [1:0] phase_drive [0:11] = '{DRIVE_NORMAL, DRIVE_INVERTED, DRIVE_NORMAL, DRIVE_SPARE,
		DRIVE_INVERTED, DRIVE_NORMAL, DRIVE_NORMAL, DRIVE_INVERTED, DRIVE_OFF, DRIVE_INVERTED,
		DRIVE_INVERTED, DRIVE_NORMAL};

	track_position_led_matrix_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [7:0] flip8(input logic [7:0] v);
		return {<<{v}};
	endfunction

	function automatic void clear_frame();
		for (int i = 0; i < 32; i++) begin
			led_bytes[i] = 8'h00;
		end
	endfunction

	function automatic void place_mark(input logic half, input logic layer,
		input logic [2:0] row, input logic [2:0] lvl, input logic rotated);
		if (rotated) begin
			led_bytes[{half, layer, row}] = 8'b1 << lvl;
		end else begin
			led_bytes[{half, layer, 3'd7 - lvl}] |= 8'b1 << row;
		end
	endfunction

	function automatic void render_track(input track_item_t t);
		logic       half;
		logic [2:0] row;
		logic [2:0] pos;
		logic [2:0] level;
		logic       rotated;
		logic       dot;
		int         quot;
		int         bar;
		half = t.track[3];
		row = t.track[2:0];
		quot = (8 * int'(t.play_step)) / (int'(t.last_step) + 1);
		pos = (quot > 7) ? 3'd7 : quot[2:0];
		level = t.meter[6:4];
		if (t.clear) begin
			clear_frame();
		end
		case (cur_mode)
			MODE_METER, MODE_METER_ROT, MODE_DOT, MODE_DOT_ROT: begin
				rotated = (cur_mode == MODE_METER_ROT) || (cur_mode == MODE_DOT_ROT);
				dot = (cur_mode == MODE_DOT) || (cur_mode == MODE_DOT_ROT);
				if (!t.muted) begin
					place_mark(half, LAYER_RED, row, pos, rotated);
				end
				if (t.meter != 8'd0) begin
					if (dot) begin
						place_mark(half, LAYER_GREEN, row, level, rotated);
					end else if (rotated) begin
						bar = (1 << (int'(level) + 1)) - 1;
						led_bytes[{half, LAYER_GREEN, row}] = bar[7:0];
					end else begin
						for (int i = 0; i <= int'(level); i++) begin
							led_bytes[{half, LAYER_GREEN, 3'(7 - i)}] |= 8'b1 << row;
						end
					end
				end
			end
			default: begin
				rotated = (cur_mode == MODE_POS_ROT);
				if (!t.muted) begin
					place_mark(half, LAYER_GREEN, row, pos, rotated);
				end
				if (t.selected) begin
					place_mark(half, LAYER_RED, row, pos, rotated);
				end
			end
		endcase
	endfunction

	function automatic void predict_transfer(input logic op, input track_item_t t);
		scan_row_t  want;
		logic [7:0] inv;
		if (cur_drive == DRIVE_OFF) begin
			return;
		end
		if (op == OP_SCAN) begin
			inv = (cur_drive == DRIVE_INVERTED) ? 8'hff : 8'h00;
			scan_pos = scan_pos + 3'd1;
			want.row = scan_pos;
			want.col_sel = flip8(~(8'b1 << scan_pos) ^ inv);
			want.green_l = flip8(led_bytes[{1'b0, LAYER_GREEN, scan_pos}] ^ inv);
			want.green_r = flip8(led_bytes[{1'b1, LAYER_GREEN, scan_pos}] ^ inv);
			want.red_l = flip8(led_bytes[{1'b0, LAYER_RED, scan_pos}] ^ inv);
			want.red_r = flip8(led_bytes[{1'b1, LAYER_RED, scan_pos}] ^ inv);
			expected_rows.push_back(want);
		end else begin
			render_track(t);
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			if (mismatches < 10) begin
				$display("[%0t] %s mismatch: expected %02h, got %02h", $time, name, want, got);
			end
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : row_checker
		scan_row_t got;
		scan_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.row = m_tdata[2:0];
			got.col_sel = m_tdata[10:3];
			got.green_l = m_tdata[18:11];
			got.green_r = m_tdata[26:19];
			got.red_l = m_tdata[34:27];
			got.red_r = m_tdata[42:35];
			if (expected_rows.size() == 0) begin
				if (mismatches < 10) begin
					$display("[%0t] row transfer with none expected: row %0d", $time, got.row);
				end
				mismatches++;
			end else begin
				want = expected_rows.pop_front();
				check_field("scan_row", 8'(want.row), 8'(got.row));
				check_field("column_select", want.col_sel, got.col_sel);
				check_field("green_left", want.green_l, got.green_l);
				check_field("green_right", want.green_r, got.green_r);
				check_field("red_left", want.red_l, got.red_l);
				check_field("red_right", want.red_r, got.red_r);
				rows_checked++;
			end
		end
	end

	function automatic track_item_t random_track();
		track_item_t t;
		t.track = 4'($urandom_range(15));
		t.last_step = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
		if ($urandom_range(7) == 0) begin
			t.play_step = 8'($urandom_range(255));
		end else begin
			t.play_step = 8'($urandom_range(int'(t.last_step)));
		end
		t.muted = ($urandom_range(4) == 0);
		t.selected = 1'($urandom_range(1));
		t.meter = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
		t.clear = ($urandom_range(15) == 0);
		return t;
	endfunction

	task automatic send_item(input logic op, input track_item_t t);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, t.clear, t.meter, t.selected, t.muted, t.play_step, t.last_step,
			t.track};
		do @(posedge clk); while (!s_tready);
		predict_transfer(op, t);
		if (op == OP_SCAN) begin
			scan_ticks++;
		end else begin
			track_updates++;
		end
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_track(input logic [3:0] track, input logic [7:0] last_step,
		input logic [7:0] play_step, input logic muted, input logic selected,
		input logic [7:0] meter, input logic clear);
		track_item_t t;
		t = '{track, last_step, play_step, muted, selected, meter, clear};
		send_item(OP_TRACK, t);
	endtask

	task automatic send_scans(input int count);
		track_item_t t;
		for (int i = 0; i < count; i++) begin
			t = random_track();
			send_item(OP_SCAN, t);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_rows.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (index == REG_DISPLAY_MODE) begin
			cur_mode = data;
		end else begin
			cur_drive = data[1:0];
		end
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [2:0] mode, input logic [1:0] drive);
		drain_results();
		write_reg(REG_DISPLAY_MODE, mode);
		write_reg(REG_DRIVE_ENABLE, {1'b0, drive});
	endtask

	task automatic test_reset_state();
		send_scans(3);
	endtask

	task automatic test_position_modes();
		apply_setting(MODE_POS, DRIVE_NORMAL);
		send_track(4'd0, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0, 1'b1);
		send_track(4'd15, 8'd0, 8'd255, 1'b0, 1'b1, 8'd255, 1'b0);
		send_track(4'd8, 8'd255, 8'd255, 1'b1, 1'b1, 8'd0, 1'b0);
		send_track(4'd7, 8'd7, 8'd3, 1'b0, 1'b0, 8'd0, 1'b0);
		send_scans(8);
		apply_setting(MODE_POS_ROT, DRIVE_INVERTED);
		send_track(4'd9, 8'd15, 8'd12, 1'b0, 1'b1, 8'd0, 1'b0);
		send_scans(2);
	endtask

	task automatic test_meter_modes();
		apply_setting(MODE_METER_ROT, DRIVE_SPARE);
		send_track(4'd3, 8'd31, 8'd5, 1'b1, 1'b1, 8'd255, 1'b1);
		send_track(4'd11, 8'd3, 8'd2, 1'b0, 1'b0, 8'h80, 1'b0);
		send_scans(3);
		apply_setting(MODE_DOT, DRIVE_INVERTED);
		send_track(4'd5, 8'd63, 8'd40, 1'b0, 1'b0, 8'h70, 1'b0);
		send_scans(2);
	endtask

	task automatic test_display_off();
		apply_setting(MODE_METER, DRIVE_OFF);
		send_track(4'd2, 8'd1, 8'd1, 1'b0, 1'b1, 8'h3f, 1'b1);
		send_scans(2);
		apply_setting(MODE_SPARE_HI, DRIVE_NORMAL);
		send_scans(3);
	endtask

	task automatic test_random_traffic(input int send_idle, input int recv_idle,
		input int first_phase);
		track_item_t t;
		logic        op;
		for (int p = first_phase; p < first_phase + 4; p++) begin
			apply_setting(phase_mode[p], phase_drive[p]);
			send_idle_pct = send_idle;
			recv_idle_pct = recv_idle;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				t = random_track();
				op = ($urandom_range(99) < 35) ? OP_SCAN : OP_TRACK;
				send_item(op, t);
			end
		end
	endtask

	initial begin
		clear_frame();
		scan_pos = 3'd0;
		cur_mode = MODE_POS;
		cur_drive = DRIVE_NORMAL;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_position_modes();
		test_meter_modes();
		test_display_off();
		test_random_traffic(23, 82, 0);
		test_random_traffic(82, 23, 4);
		test_random_traffic(0, 0, 8);
		drain_results();

		if (expected_rows.size() != 0) begin
			mismatches++;
		end
		$display("Sent %0d track updates and %0d scan ticks; compared %0d scanned rows.",
			track_updates, scan_ticks, rows_checked);
		$display("Swept all display modes and drive codes under varying backpressure.");
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
